### hw/rtl/rch_pkg.sv
package rch_pkg;

	// Default table geometry
	localparam int MAX_CHIPS_X_DEF = 8;
	localparam int MAX_CHIPS_Y_DEF = 8;
	localparam int MAX_CORES_DEF   = 16;

	// Commands, coded as the mode field of an input word
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TICK  = 2'd1,
		OP_SACK  = 2'd2,
		OP_TACK  = 2'd3
	} op_t;

	// Result kinds
	localparam logic [1:0] KIND_STATUS  = 2'd0;
	localparam logic [1:0] KIND_TRACE   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// Table entry kinds
	localparam logic [1:0] ENT_IGNORED = 2'd0;
	localparam logic [1:0] ENT_WAITING = 2'd1;
	localparam logic [1:0] ENT_HAS_ID  = 2'd2;
	localparam logic [1:0] ENT_TRACING = 2'd3;

	// Handshake phases
	localparam logic [1:0] PH_RECRUIT = 2'd0;
	localparam logic [1:0] PH_TRACE   = 2'd1;
	localparam logic [1:0] PH_DONE    = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_CHIPS_ACROSS   = 3'd0;
	localparam logic [2:0] REG_CHIPS_DOWN     = 3'd1;
	localparam logic [2:0] REG_CORES_PER_CHIP = 3'd2;
	localparam logic [2:0] REG_STATUS_TRIES   = 3'd3;
	localparam logic [2:0] REG_TRACE_TRIES    = 3'd4;
	localparam logic [2:0] REG_SENDS_PER_TICK = 3'd5;

	// Register reset values
	localparam logic [3:0] RST_CHIPS_ACROSS   = 4'd8;
	localparam logic [3:0] RST_CHIPS_DOWN     = 4'd8;
	localparam logic [4:0] RST_CORES_PER_CHIP = 5'd16;
	localparam logic [5:0] RST_STATUS_TRIES   = 6'd11;
	localparam logic [5:0] RST_TRACE_TRIES    = 6'd35;
	localparam logic [5:0] RST_SENDS_PER_TICK = 6'd51;

	localparam logic [5:0] SEND_CAP = 6'd51;
	localparam logic [9:0] ID_MAX   = 10'd1023;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] src_x;
		logic [2:0] src_y;
		logic [3:0] src_core;
	} in_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] dest_x;
		logic [2:0] dest_y;
		logic [3:0] dest_core;
		logic [9:0] node_id;
		logic [9:0] node_total;
		logic [1:0] phase;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [3:0] chips_across;
		logic [3:0] chips_down;
		logic [4:0] cores_per_chip;
		logic [5:0] status_tries;
		logic [5:0] trace_tries;
		logic [5:0] sends_per_tick;
	} cfg_t;

	// Region counts after limiting to the table geometry
	typedef struct packed {
		logic [3:0] nx;
		logic [3:0] ny;
		logic [4:0] nc;
	} region_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] x;
		logic [2:0] y;
		logic [3:0] c;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] tries;
		logic [9:0] id;
	} entry_t;

	typedef struct packed {
		logic       busy;
		logic       armed;
		logic [1:0] phase;
	} status_t;

endpackage

### hw/rtl/rch_front.sv
module rch_front import rch_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_word,
	input  region_t  region,
	output logic     q_valid,
	output cmd_t     q_cmd,
	input  logic     q_pop
);

	localparam int QD = 2;

	cmd_t       slots_q [QD];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	cmd_t dec;
	logic in_region;
	logic keep;
	logic push;

	always_comb begin
		dec.x = in_word.src_x;
		dec.y = in_word.src_y;
		dec.c = in_word.src_core;
		unique case (in_word.mode)
			OP_START: dec.op = OP_START;
			OP_TICK:  dec.op = OP_TICK;
			OP_SACK:  dec.op = OP_SACK;
			OP_TACK:  dec.op = OP_TACK;
			default:  dec.op = OP_TICK;
		endcase
		in_region = ({1'b0, in_word.src_x} < region.nx) &&
			({1'b0, in_word.src_y} < region.ny) &&
			({1'b0, in_word.src_core} < region.nc);
		// drop acks from nodes outside the region here
		keep = (dec.op == OP_START) || (dec.op == OP_TICK) || in_region;
	end

	assign in_stall = (cnt_q == 2'(QD));
	assign push     = in_valid && !in_stall && keep;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/rch_back.sv
module rch_back import rch_pkg::*; #(
	parameter int MAX_CHIPS_X = MAX_CHIPS_X_DEF,
	parameter int MAX_CHIPS_Y = MAX_CHIPS_Y_DEF,
	parameter int MAX_CORES   = MAX_CORES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  region_t   region,
	input  logic      q_valid,
	input  cmd_t      q_cmd,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word,
	output status_t   sts
);

	localparam int XW    = (MAX_CHIPS_X > 1) ? $clog2(MAX_CHIPS_X) : 1;
	localparam int YW    = (MAX_CHIPS_Y > 1) ? $clog2(MAX_CHIPS_Y) : 1;
	localparam int CW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int AW    = XW + YW + CW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CLEAR = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_SUM   = 5'b01000,
		ST_ACK   = 5'b10000
	} state_t;

	entry_t mem [DEPTH];
	entry_t rdata_s1;

	state_t     state_q;
	logic       armed_q;
	logic [1:0] phase_q;
	logic [9:0] next_id_q;
	logic [AW-1:0] clr_q;
	logic [3:0] cx_q;
	logic [3:0] cy_q;
	logic [4:0] cc_q;
	logic       cur_done_q;
	logic       pend_s1;
	logic [3:0] px_s1;
	logic [3:0] py_s1;
	logic [4:0] pc_s1;
	logic [5:0] sent_q;
	logic       stop_q;
	op_t        ack_op_q;
	out_word_t  out_q;
	logic       out_valid_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	logic [1:0] want;
	logic [5:0] tries_lim;
	logic [5:0] send_lim;
	logic       hit;
	logic       drop;
	logic       msg;
	logic       out_free;
	logic       consume;
	logic       advance;
	logic       stop_now;
	logic       issue;
	logic       ack_grant;
	logic       load_msg;
	logic       load_sum;

	function automatic logic [AW-1:0] node_addr(logic [3:0] x, logic [3:0] y, logic [4:0] c);
		return {XW'(x), YW'(y), CW'(c)};
	endfunction

	always_comb begin
		want      = (phase_q == PH_RECRUIT) ? ENT_WAITING : ENT_HAS_ID;
		tries_lim = (phase_q == PH_RECRUIT) ? cfg.status_tries : cfg.trace_tries;
		if (cfg.sends_per_tick == 6'd0) send_lim = 6'd1;
		else if (cfg.sends_per_tick > SEND_CAP) send_lim = SEND_CAP;
		else send_lim = cfg.sends_per_tick;

		hit      = pend_s1 && (rdata_s1.kind == want);
		drop     = hit && (rdata_s1.tries >= tries_lim);
		msg      = hit && !drop;
		out_free = !out_valid_q || !out_stall;
		// hold the read entry while its message cannot go out
		consume  = pend_s1 && (!msg || out_free);
		advance  = !pend_s1 || consume;
		stop_now = stop_q ||
			(msg && consume && (({1'b0, sent_q} + 7'd1) >= {1'b0, send_lim}));
		issue    = advance && !cur_done_q && !stop_now;

		ack_grant = (ack_op_q == OP_SACK) && (phase_q == PH_RECRUIT) &&
			(rdata_s1.kind == ENT_WAITING) && (next_id_q < ID_MAX);

		load_msg = (state_q == ST_SCAN) && consume && msg;
		load_sum = (state_q == ST_SUM) && out_free;

		mem_we    = 1'b0;
		mem_waddr = node_addr(px_s1, py_s1, pc_s1);
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = node_addr(cx_q, cy_q, cc_q);

		unique case (state_q)
			ST_IDLE: begin
				mem_re    = q_valid;
				mem_raddr = node_addr({1'b0, q_cmd.x}, {1'b0, q_cmd.y}, {1'b0, q_cmd.c});
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == '0) ? entry_t'('0) :
					entry_t'{kind: ENT_WAITING, tries: 6'd0, id: 10'd0};
			end
			ST_SCAN: begin
				if (consume && hit) begin
					mem_we    = 1'b1;
					mem_wdata = drop ? entry_t'('0) :
						entry_t'{kind: want, tries: rdata_s1.tries + 6'd1, id: rdata_s1.id};
				end
				mem_re = issue;
			end
			ST_ACK: begin
				if (ack_grant) begin
					mem_we    = 1'b1;
					mem_wdata = '{kind: ENT_HAS_ID, tries: 6'd0, id: next_id_q};
				end else if ((ack_op_q == OP_TACK) && (phase_q == PH_TRACE)) begin
					mem_we    = 1'b1;
					mem_wdata = '{kind: ENT_TRACING, tries: 6'd0, id: 10'd0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			px_s1    <= {1'b0, q_cmd.x};
			py_s1    <= {1'b0, q_cmd.y};
			pc_s1    <= {1'b0, q_cmd.c};
			ack_op_q <= q_cmd.op;
		end else if (state_q == ST_SCAN && issue) begin
			px_s1 <= cx_q;
			py_s1 <= cy_q;
			pc_s1 <= cc_q;
		end
		if (load_msg) begin
			out_q.kind       <= (phase_q == PH_RECRUIT) ? KIND_STATUS : KIND_TRACE;
			out_q.dest_x     <= px_s1[2:0];
			out_q.dest_y     <= py_s1[2:0];
			out_q.dest_core  <= pc_s1[3:0];
			out_q.node_id    <= (phase_q == PH_RECRUIT) ? 10'd0 : rdata_s1.id;
			out_q.node_total <= next_id_q;
			out_q.phase      <= phase_q;
			out_q.last       <= 1'b0;
		end else if (load_sum) begin
			out_q.kind       <= KIND_SUMMARY;
			out_q.dest_x     <= 3'd0;
			out_q.dest_y     <= 3'd0;
			out_q.dest_core  <= 4'd0;
			out_q.node_id    <= 10'd0;
			out_q.node_total <= next_id_q;
			out_q.phase      <= (sent_q == 6'd0) ? phase_q + 2'd1 : phase_q;
			out_q.last       <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			armed_q     <= 1'b0;
			phase_q     <= PH_RECRUIT;
			next_id_q   <= 10'd0;
			clr_q       <= '0;
			cx_q        <= 4'd0;
			cy_q        <= 4'd0;
			cc_q        <= 5'd0;
			cur_done_q  <= 1'b0;
			pend_s1     <= 1'b0;
			sent_q      <= 6'd0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_msg || load_sum) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && phase_q != PH_DONE) begin
						unique case (q_cmd.op) inside
							OP_START: begin
								armed_q <= 1'b1;
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							OP_TICK: begin
								if (armed_q) begin
									cx_q       <= 4'd0;
									cy_q       <= 4'd0;
									cc_q       <= 5'd0;
									cur_done_q <= (region.nx == 4'd0) ||
										(region.ny == 4'd0) || (region.nc == 5'd0);
									pend_s1    <= 1'b0;
									sent_q     <= 6'd0;
									stop_q     <= 1'b0;
									state_q    <= ST_SCAN;
								end
							end
							OP_SACK, OP_TACK: begin
								if (armed_q) state_q <= ST_ACK;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (load_msg) sent_q <= sent_q + 6'd1;
					stop_q <= stop_now;
					if (issue) begin
						pend_s1 <= 1'b1;
						// advance in core, then y, then x order
						if (cc_q == region.nc - 5'd1) begin
							cc_q <= 5'd0;
							if (cy_q == region.ny - 4'd1) begin
								cy_q <= 4'd0;
								if (cx_q == region.nx - 4'd1) cur_done_q <= 1'b1;
								else cx_q <= cx_q + 4'd1;
							end else begin
								cy_q <= cy_q + 4'd1;
							end
						end else begin
							cc_q <= cc_q + 5'd1;
						end
					end else if (advance) begin
						pend_s1 <= 1'b0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						if (sent_q == 6'd0) phase_q <= phase_q + 2'd1;
						state_q <= ST_IDLE;
					end
				end
				ST_ACK: begin
					if (ack_grant) next_id_q <= next_id_q + 10'd1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign sts.busy  = (state_q != ST_IDLE);
	assign sts.armed = armed_q;
	assign sts.phase = phase_q;

endmodule

### hw/rtl/node_recruit_handshake.sv
// Node recruiting handshake engine.
// Input words (in_word, in_valid/in_stall) carry start, tick, status ack and
// trace ack commands. They enter a two-word queue; acks from nodes outside the
// configured region are dropped there. One command is carried out at a time.
// Output words (out_word, out_valid/out_stall) are status queries, trace
// commands and one tick summary (last set) per tick.
// Start: clears the node table in one write per entry, 2^(address bits)
// entries (1024 with the default geometry), and gives no output.
// Tick: reads one table entry per cycle unless the output stalls, in x, y,
// core order, ends early after the send limit, and then sends the summary.
// Ack: gives no output.
// The queue holds each command in a register until the back end takes it.
// A stalled output holds the scan on the entry that wants to send; input
// stalls only when the queue is full.
// Reset clears the queue, phase, ID counter and armed flag; the table is
// unknown until the first start. Configuration is taken with cfg_we.
module node_recruit_handshake import rch_pkg::*; #(
	parameter int MAX_CHIPS_X = MAX_CHIPS_X_DEF,
	parameter int MAX_CHIPS_Y = MAX_CHIPS_Y_DEF,
	parameter int MAX_CORES   = MAX_CORES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	cfg_t    cfg_q;
	region_t region;
	logic    q_valid;
	cmd_t    q_cmd;
	logic    q_pop;
	status_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chips_across   <= RST_CHIPS_ACROSS;
			cfg_q.chips_down     <= RST_CHIPS_DOWN;
			cfg_q.cores_per_chip <= RST_CORES_PER_CHIP;
			cfg_q.status_tries   <= RST_STATUS_TRIES;
			cfg_q.trace_tries    <= RST_TRACE_TRIES;
			cfg_q.sends_per_tick <= RST_SENDS_PER_TICK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHIPS_ACROSS:   cfg_q.chips_across   <= cfg_data[3:0];
				REG_CHIPS_DOWN:     cfg_q.chips_down     <= cfg_data[3:0];
				REG_CORES_PER_CHIP: cfg_q.cores_per_chip <= cfg_data[4:0];
				REG_STATUS_TRIES:   cfg_q.status_tries   <= cfg_data;
				REG_TRACE_TRIES:    cfg_q.trace_tries    <= cfg_data;
				REG_SENDS_PER_TICK: cfg_q.sends_per_tick <= cfg_data;
				default: ;
			endcase
		end
	end

	// Limit the region to the table geometry
	always_comb begin
		region.nx = (32'(cfg_q.chips_across) > MAX_CHIPS_X) ? 4'(MAX_CHIPS_X) :
			cfg_q.chips_across;
		region.ny = (32'(cfg_q.chips_down) > MAX_CHIPS_Y) ? 4'(MAX_CHIPS_Y) :
			cfg_q.chips_down;
		region.nc = (32'(cfg_q.cores_per_chip) > MAX_CORES) ? 5'(MAX_CORES) :
			cfg_q.cores_per_chip;
	end

	rch_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.region   (region),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	rch_back #(
		.MAX_CHIPS_X (MAX_CHIPS_X),
		.MAX_CHIPS_Y (MAX_CHIPS_Y),
		.MAX_CORES   (MAX_CORES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.region    (region),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.sts       (sts)
	);

`ifndef SYNTHESIS
	a_phase_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		sts.phase >= $past(sts.phase))
		else $error("handshake phase went backward");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.phase == PH_DONE |-> !sts.busy)
		else $error("back end busy after the last phase");

	a_out_armed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sts.armed)
		else $error("output word before the first start");

	a_msg_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.last) |->
		(((out_word.kind == KIND_STATUS) && (out_word.phase == PH_RECRUIT) &&
		(out_word.node_id == 10'd0)) ||
		((out_word.kind == KIND_TRACE) && (out_word.phase == PH_TRACE))))
		else $error("message kind does not match its phase");
`endif

endmodule

### tb/sv/node_recruit_handshake_test.sv
module node_recruit_handshake_test;
	import rch_pkg::*;

	localparam int DEPTH = MAX_CHIPS_X_DEF * MAX_CHIPS_Y_DEF * MAX_CORES_DEF;
	// covers three table clears still in flight after the last result
	localparam int SETTLE = 3200;
	localparam int HOLD_CYCLES = 600;
	localparam int LIMIT = 3000000;

	typedef struct {
		in_word_t  w;
		bit        typed;
		int        cnt;
		out_word_t r0;
		out_word_t r1;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_we;
	logic [2:0] cfg_index;
	logic [5:0] cfg_data;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;

	// model of the block
	cfg_t       regs;
	entry_t     tbl [DEPTH];
	logic [9:0] nid;
	logic [1:0] ph;
	bit         is_armed;

	out_word_t  step_out[$];
	out_word_t  due_q[$];
	plan_row_t  plan[$];

	int  bad = 0;
	int  cycles = 0;
	bit  quiet;
	bit  hold_req;
	bit  held = 1'b0;
	int  hold_left = 0;

	node_recruit_handshake u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic in_word_t word(input op_t op, input int x, input int y, input int c);
		in_word_t w;
		w.mode = op;
		w.src_x = 3'(x);
		w.src_y = 3'(y);
		w.src_core = 4'(c);
		return w;
	endfunction

	function automatic out_word_t res(input logic [1:0] kind, input int x, input int y,
			input int c, input int id, input logic [9:0] total, input logic [1:0] phase,
			input bit last);
		out_word_t r;
		r.kind = kind;
		r.dest_x = 3'(x);
		r.dest_y = 3'(y);
		r.dest_core = 4'(c);
		r.node_id = 10'(id);
		r.node_total = total;
		r.phase = phase;
		r.last = last;
		return r;
	endfunction

	function automatic region_t region_now();
		region_t rg;
		rg.nx = (int'(regs.chips_across) > MAX_CHIPS_X_DEF) ? 4'(MAX_CHIPS_X_DEF) :
			regs.chips_across;
		rg.ny = (int'(regs.chips_down) > MAX_CHIPS_Y_DEF) ? 4'(MAX_CHIPS_Y_DEF) :
			regs.chips_down;
		rg.nc = (int'(regs.cores_per_chip) > MAX_CORES_DEF) ? 5'(MAX_CORES_DEF) :
			regs.cores_per_chip;
		return rg;
	endfunction

	function automatic int slot(input int x, input int y, input int c);
		return (x * MAX_CHIPS_Y_DEF + y) * MAX_CORES_DEF + c;
	endfunction

	// True when a tick in the current phase would send at least one message.
	function automatic bit tick_sends();
		region_t    rg;
		logic [1:0] want;
		logic [5:0] tries;
		int         x, y, c;
		rg = region_now();
		want = (ph == PH_RECRUIT) ? ENT_WAITING : ENT_HAS_ID;
		tries = (ph == PH_RECRUIT) ? regs.status_tries : regs.trace_tries;
		for (x = 0; x < int'(rg.nx); x++)
			for (y = 0; y < int'(rg.ny); y++)
				for (c = 0; c < int'(rg.nc); c++)
					if (tbl[slot(x, y, c)].kind == want && tbl[slot(x, y, c)].tries < tries)
						return 1'b1;
		return 1'b0;
	endfunction

	function automatic void recruit_step(input in_word_t w);
		region_t    rg;
		op_t        op;
		logic [1:0] want;
		logic [5:0] tries;
		entry_t     e;
		int         s, n, cap, x, y, c, i;
		bit         halt;
		step_out.delete();
		rg = region_now();
		op = op_t'(w.mode);
		if (ph >= PH_DONE)
			return;
		if (op == OP_START) begin
			for (i = 0; i < DEPTH; i++) begin
				tbl[i] = '0;
				if (i != 0)
					tbl[i].kind = ENT_WAITING;
			end
			is_armed = 1'b1;
			return;
		end
		if (!is_armed)
			return;
		if (op == OP_SACK || op == OP_TACK) begin
			if ({1'b0, w.src_x} >= rg.nx || {1'b0, w.src_y} >= rg.ny ||
					{1'b0, w.src_core} >= rg.nc)
				return;
			s = slot(int'(w.src_x), int'(w.src_y), int'(w.src_core));
			if (op == OP_SACK) begin
				if (ph == PH_RECRUIT && tbl[s].kind == ENT_WAITING && nid < ID_MAX) begin
					tbl[s] = '0;
					tbl[s].kind = ENT_HAS_ID;
					tbl[s].id = nid;
					nid = nid + 10'd1;
				end
			end else if (ph == PH_TRACE) begin
				tbl[s] = '0;
				tbl[s].kind = ENT_TRACING;
			end
			return;
		end
		cap = int'(regs.sends_per_tick);
		if (cap < 1)
			cap = 1;
		if (cap > int'(SEND_CAP))
			cap = int'(SEND_CAP);
		want = (ph == PH_RECRUIT) ? ENT_WAITING : ENT_HAS_ID;
		tries = (ph == PH_RECRUIT) ? regs.status_tries : regs.trace_tries;
		n = 0;
		halt = 1'b0;
		for (x = 0; x < int'(rg.nx) && !halt; x++)
			for (y = 0; y < int'(rg.ny) && !halt; y++)
				for (c = 0; c < int'(rg.nc) && !halt; c++) begin
					s = slot(x, y, c);
					e = tbl[s];
					if (e.kind == want) begin
						if (e.tries >= tries) begin
							// drop silently, no send counted
							tbl[s] = '0;
						end else begin
							tbl[s].tries = e.tries + 6'd1;
							if (ph == PH_RECRUIT)
								step_out.push_back(res(KIND_STATUS, x, y, c, 0, nid, ph, 1'b0));
							else
								step_out.push_back(res(KIND_TRACE, x, y, c, int'(e.id), nid, ph,
									1'b0));
							n++;
							if (n >= cap)
								halt = 1'b1;
						end
					end
				end
		if (n == 0)
			ph = ph + 2'd1;
		step_out.push_back(res(KIND_SUMMARY, 0, 0, 0, 0, nid, ph, 1'b1));
	endfunction

	function automatic string diff_fields(input out_word_t e, input out_word_t g);
		string s = "";
		if (e.kind !== g.kind) s = {s, " kind"};
		if (e.dest_x !== g.dest_x) s = {s, " dest_x"};
		if (e.dest_y !== g.dest_y) s = {s, " dest_y"};
		if (e.dest_core !== g.dest_core) s = {s, " dest_core"};
		if (e.node_id !== g.node_id) s = {s, " node_id"};
		if (e.node_total !== g.node_total) s = {s, " node_total"};
		if (e.phase !== g.phase) s = {s, " phase"};
		if (e.last !== g.last) s = {s, " last"};
		return s;
	endfunction

	// Check every word taken from the output against the oldest one due.
	always @(posedge clk) begin
		out_word_t e;
		string     d;
		if (arst_n && out_valid && !out_stall) begin
			if (due_q.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("unexpected word %h at cycle %0d", out_word, cycles);
			end else begin
				e = due_q.pop_front();
				d = diff_fields(e, out_word);
				if (d != "") begin
					bad++;
					if (bad <= 10)
						$display("bad word at cycle %0d:%s exp %h got %h", cycles, d, e, out_word);
				end
			end
		end
	end

	// Receiver: random stall, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_req && !held) begin
			held <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 33);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("node_recruit_handshake: mismatch");
			$finish;
		end
	end

	task automatic push_word(input in_word_t w);
		while (!quiet && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic feed(input in_word_t w);
		push_word(w);
		recruit_step(w);
		foreach (step_out[i])
			due_q.push_back(step_out[i]);
	endtask

	task automatic plan_row(input in_word_t w, input bit typed, input int cnt,
			input out_word_t r0, input out_word_t r1);
		plan_row_t p;
		p.w = w;
		p.typed = typed;
		p.cnt = cnt;
		p.r0 = r0;
		p.r1 = r1;
		plan.push_back(p);
	endtask

	task automatic run_plan();
		foreach (plan[i]) begin
			if (plan[i].typed) begin
				push_word(plan[i].w);
				recruit_step(plan[i].w);
				if (plan[i].cnt > 0) due_q.push_back(plan[i].r0);
				if (plan[i].cnt > 1) due_q.push_back(plan[i].r1);
			end else begin
				feed(plan[i].w);
			end
		end
		plan.delete();
	endtask

	// Drop valid, wait for every due word, then let any table clears finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (due_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_put(input logic [2:0] idx, input logic [5:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_regs(input int across, input int down, input int cores,
			input int stries, input int ttries, input int sends);
		cfg_t c;
		c.chips_across = 4'(across);
		c.chips_down = 4'(down);
		c.cores_per_chip = 5'(cores);
		c.status_tries = 6'(stries);
		c.trace_tries = 6'(ttries);
		c.sends_per_tick = 6'(sends);
		reg_put(REG_CHIPS_ACROSS, 6'(c.chips_across));
		reg_put(REG_CHIPS_DOWN, 6'(c.chips_down));
		reg_put(REG_CORES_PER_CHIP, 6'(c.cores_per_chip));
		reg_put(REG_STATUS_TRIES, c.status_tries);
		reg_put(REG_TRACE_TRIES, c.trace_tries);
		reg_put(REG_SENDS_PER_TICK, c.sends_per_tick);
		cfg_we <= 1'b0;
		regs = c;
	endtask

	// Ack source: mostly inside the region, sometimes anywhere.
	function automatic in_word_t ack_word(input op_t op);
		region_t rg;
		rg = region_now();
		if ($urandom_range(9) < 8)
			return word(op, $urandom_range(int'(rg.nx) - 1), $urandom_range(int'(rg.ny) - 1),
				$urandom_range(int'(rg.nc) - 1));
		return word(op, $urandom_range(7), $urandom_range(7), $urandom_range(15));
	endfunction

	// Ticks are issued only when they keep the phase; otherwise re-arm or ack.
	task automatic random_items(input int count);
		in_word_t w;
		int       r;
		repeat (count) begin
			r = $urandom_range(99);
			if (ph == PH_RECRUIT) begin
				if (r < 8 || (r < 45 && !tick_sends()))
					w = word(OP_START, $urandom_range(7), $urandom_range(7), $urandom_range(15));
				else if (r < 45)
					w = word(OP_TICK, $urandom_range(7), $urandom_range(7), $urandom_range(15));
				else if (r < 90)
					w = ack_word(OP_SACK);
				else
					w = ack_word(OP_TACK);
			end else begin
				if (r < 55 && tick_sends())
					w = word(OP_TICK, $urandom_range(7), $urandom_range(7), $urandom_range(15));
				else if (r < 85)
					w = ack_word(OP_TACK);
				else
					w = ack_word(OP_SACK);
			end
			feed(w);
		end
	endtask

	initial begin
		int a, d, c, k;
		out_word_t none;
		none = '0;
		regs.chips_across = RST_CHIPS_ACROSS;
		regs.chips_down = RST_CHIPS_DOWN;
		regs.cores_per_chip = RST_CORES_PER_CHIP;
		regs.status_tries = RST_STATUS_TRIES;
		regs.trace_tries = RST_TRACE_TRIES;
		regs.sends_per_tick = RST_SENDS_PER_TICK;
		foreach (tbl[i])
			tbl[i] = '0;
		nid = '0;
		ph = PH_RECRUIT;
		is_armed = 1'b0;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CHIPS_ACROSS;
		cfg_data <= '0;
		quiet <= 1'b0;
		hold_req <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_regs(1, 1, 3, 1, 35, 1);
		// nothing acts before the first start
		plan_row(word(OP_TICK, 0, 0, 0), 1, 0, none, none);
		plan_row(word(OP_SACK, 0, 0, 1), 1, 0, none, none);
		plan_row(word(OP_TACK, 7, 7, 15), 1, 0, none, none);
		plan_row(word(OP_START, 7, 7, 15), 1, 0, none, none);
		plan_row(word(OP_TICK, 0, 0, 0), 1, 2,
			res(KIND_STATUS, 0, 0, 1, 0, 0, PH_RECRUIT, 0),
			res(KIND_SUMMARY, 0, 0, 0, 0, 0, PH_RECRUIT, 1));
		// node 0,0,1 is out of tries: dropped, next node takes the one send
		plan_row(word(OP_TICK, 7, 7, 15), 1, 2,
			res(KIND_STATUS, 0, 0, 2, 0, 0, PH_RECRUIT, 0),
			res(KIND_SUMMARY, 0, 0, 0, 0, 0, PH_RECRUIT, 1));
		plan_row(word(OP_SACK, 0, 0, 1), 1, 0, none, none);
		plan_row(word(OP_SACK, 0, 0, 2), 1, 0, none, none);
		plan_row(word(OP_SACK, 0, 0, 2), 1, 0, none, none);
		plan_row(word(OP_SACK, 7, 7, 15), 1, 0, none, none);
		plan_row(word(OP_SACK, 0, 0, 0), 1, 0, none, none);
		plan_row(word(OP_TACK, 0, 0, 2), 1, 0, none, none);
		plan_row(word(OP_START, 0, 0, 0), 1, 0, none, none);
		plan_row(word(OP_SACK, 0, 0, 1), 1, 0, none, none);
		plan_row(word(OP_TICK, 0, 0, 0), 0, 0, none, none);
		run_plan();

		settle();
		load_regs(8, 8, 16, 11, 35, 51);
		random_items(10);
		hold_req <= 1'b1;
		random_items(40);

		// counts above the geometry and an oversized send limit
		settle();
		load_regs(15, 3, 31, 63, 1, 63);
		random_items(50);

		settle();
		a = $urandom_range(8, 1);
		d = $urandom_range(8, 1);
		c = $urandom_range(16, 1);
		if (a * d * c < 2)
			c = 2;
		load_regs(a, d, c, $urandom_range(63, 1), $urandom_range(63, 1), $urandom_range(51, 1));
		random_items(50);

		// hand out a few IDs with no idling
		settle();
		quiet <= 1'b1;
		load_regs(8, 8, 16, 11, 35, 51);
		feed(word(OP_START, 0, 0, 0));
		for (k = 1; k <= 20; k++)
			feed(word(OP_SACK, 0, k / MAX_CORES_DEF, k % MAX_CORES_DEF));
		feed(word(OP_TICK, 0, 0, 0));

		// zero status tries drops every waiting node, so the phase moves on
		settle();
		load_regs(8, 8, 16, 0, 63, 51);
		feed(word(OP_TICK, 0, 0, 0));

		settle();
		load_regs(8, 8, 16, 1, 63, 51);
		random_items(50);
		quiet <= 1'b0;

		settle();
		a = $urandom_range(8, 1);
		d = $urandom_range(8, 1);
		c = $urandom_range(16, 1);
		if (a * d * c < 2)
			c = 2;
		load_regs(a, d, c, $urandom_range(63, 1), $urandom_range(63, 1), $urandom_range(51, 1));
		random_items(50);

		settle();
		load_regs(8, 8, 16, 1, 2, 17);
		random_items(50);

		// a start in the trace phase leaves nothing to trace: the next tick ends the run
		plan_row(word(OP_START, 0, 0, 0), 1, 0, none, none);
		plan_row(word(OP_TICK, 0, 0, 0), 0, 0, none, none);
		plan_row(word(OP_START, 7, 7, 15), 1, 0, none, none);
		plan_row(word(OP_TICK, 7, 7, 15), 1, 0, none, none);
		plan_row(word(OP_SACK, 0, 0, 1), 1, 0, none, none);
		plan_row(word(OP_TACK, 0, 0, 1), 1, 0, none, none);
		run_plan();

		in_valid <= 1'b0;
		while (due_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (bad == 0)
			$display("node_recruit_handshake: match");
		else
			$display("node_recruit_handshake: mismatch");
		$finish;
	end

endmodule

### sim.f
hw/rtl/rch_pkg.sv
hw/rtl/rch_front.sv
hw/rtl/rch_back.sv
hw/rtl/node_recruit_handshake.sv
tb/sv/node_recruit_handshake_test.sv
